[hdl/lfus_pkg.sv]
`default_nettype none

package lfus_pkg;

   localparam int SLOTS = 16;
   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int KEY_W = 16;
   localparam int CNT_W = 16;
   localparam int AGE_W = 16;
   localparam int CFG_W = 5;
   localparam int OUT_DATA_W = 40;
   localparam int OUT_USER_W = 2;

   localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(16);

   typedef logic [IDX_W-1:0] slot_idx_type;
   typedef logic [CNT_W-1:0] count_type;
   typedef logic [AGE_W-1:0] age_type;
   typedef logic [KEY_W-1:0] key_type;

   typedef count_type [SLOTS-1:0] count_vec_type;
   typedef age_type [SLOTS-1:0] age_vec_type;

   function automatic logic [15:0] sat_inc(input logic [15:0] v);
      return (v == 16'hFFFF) ? v : v + 16'd1;
   endfunction

endpackage

`default_nettype wire

[hdl/lfus_victim_tree.sv]
`default_nettype none

module lfus_victim_tree (
   input  lfus_pkg::count_vec_type      counts,
   input  lfus_pkg::age_vec_type        ages,
   input  wire [lfus_pkg::SLOTS-1:0]    live,
   output lfus_pkg::slot_idx_type       victim
);

   typedef struct packed {
      logic                   live;
      lfus_pkg::count_type    count;
      lfus_pkg::age_type      age;
      lfus_pkg::slot_idx_type idx;
   } node_type;

   localparam int NODES = 2 * lfus_pkg::SLOTS - 1;

   node_type node [NODES];

   // right side wins only when strictly better: lower count, then older
   function automatic node_type pick(input node_type a, input node_type b);
      logic take_b;
      take_b = b.live && (!a.live || (b.count < a.count) ||
               ((b.count == a.count) && (b.age > a.age)));
      return take_b ? b : a;
   endfunction

   always_comb begin
      for (int i = 0; i < lfus_pkg::SLOTS; i++) begin
         node[lfus_pkg::SLOTS-1+i].live  = live[i];
         node[lfus_pkg::SLOTS-1+i].count = counts[i];
         node[lfus_pkg::SLOTS-1+i].age   = ages[i];
         node[lfus_pkg::SLOTS-1+i].idx   = lfus_pkg::IDX_W'(i);
      end
      for (int n = lfus_pkg::SLOTS - 2; n >= 0; n--) begin
         node[n] = pick(node[2*n+1], node[2*n+2]);
      end
   end

   assign victim = node[0].idx;

endmodule

`default_nettype wire

[hdl/lfu_slot_replacement_oldest_tie_unit.sv]
`default_nettype none

// LFU slot table with oldest-first tie break. Each item on req carries a
// 16-bit key; one result per item comes back on rsp, in order, passing through
// the input register and then the result register. A new item is taken every
// cycle while rsp is not stalled: the whole lookup, age update, and victim choice
// (a four-level compare tree over the 16 slot registers) are combinational between
// the input and result registers. csr_wdata sets the number of active slots
// (0 acts as 1, above 16 acts as 16); write it only while the block is idle.
module lfu_slot_replacement_oldest_tie_unit (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               req_tvalid,
   output logic                              req_tready,
   input  wire  [15:0]                       req_tdata,   // candidate_id
   output logic                              rsp_tvalid,
   input  wire                               rsp_tready,
   // evicted_id[15:0], slot_index[19:16], count_after[35:20], zero pad
   output logic [lfus_pkg::OUT_DATA_W-1:0]   rsp_tdata,
   // was_hit[0], did_evict[1]
   output logic [lfus_pkg::OUT_USER_W-1:0]   rsp_tuser,
   input  wire                               csr_we,
   input  wire  [lfus_pkg::CFG_W-1:0]        csr_wdata
);

   localparam int N = lfus_pkg::SLOTS;

   logic [lfus_pkg::CFG_W-1:0] frames_ff;
   logic                       in_valid_ff;
   lfus_pkg::key_type          in_key_ff;
   logic                       advance;

   logic [N-1:0]               slot_valid_ff;
   lfus_pkg::key_type          slot_key_ff [N];
   lfus_pkg::count_vec_type    slot_count_ff;
   lfus_pkg::age_vec_type      slot_age_ff;

   logic                       rsp_valid_ff;
   logic                       hit_ff, evict_ff;
   lfus_pkg::key_type          gone_ff;
   lfus_pkg::slot_idx_type     slot_ff;
   lfus_pkg::count_type        cnt_ff;

   logic [lfus_pkg::CFG_W-1:0] lim;
   logic [N-1:0]               active, live;
   lfus_pkg::age_vec_type      age_raised;
   lfus_pkg::age_vec_type      age_next;
   logic                       hit, free_found;
   lfus_pkg::slot_idx_type     hit_slot, free_slot, victim, slot_in;
   lfus_pkg::count_type        cnt_in;
   lfus_pkg::key_type          gone_in;

   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_comb begin
      if (frames_ff == '0) begin
         lim = lfus_pkg::CFG_W'(1);
      end else if (frames_ff > lfus_pkg::CFG_W'(N)) begin
         lim = lfus_pkg::CFG_W'(N);
      end else begin
         lim = frames_ff;
      end
   end

   always_comb begin
      hit        = 1'b0;
      free_found = 1'b0;
      hit_slot   = '0;
      free_slot  = '0;
      for (int i = 0; i < N; i++) begin
         active[i]     = lfus_pkg::CFG_W'(i) < lim;
         live[i]       = active[i] && slot_valid_ff[i];
         age_raised[i] = live[i] ? lfus_pkg::sat_inc(slot_age_ff[i]) : slot_age_ff[i];
         if (live[i] && (slot_key_ff[i] == in_key_ff) && !hit) begin
            hit      = 1'b1;
            hit_slot = lfus_pkg::IDX_W'(i);
         end
         if (active[i] && !slot_valid_ff[i] && !free_found) begin
            free_found = 1'b1;
            free_slot  = lfus_pkg::IDX_W'(i);
         end
      end
   end

   lfus_victim_tree u_victim (
      .counts (slot_count_ff),
      .ages   (age_raised),
      .live   (live),
      .victim (victim)
   );

   always_comb begin
      gone_in = '0;
      if (hit) begin
         slot_in = hit_slot;
         cnt_in  = lfus_pkg::sat_inc(slot_count_ff[hit_slot]);
      end else if (free_found) begin
         slot_in = free_slot;
         cnt_in  = lfus_pkg::CNT_W'(1);
      end else begin
         slot_in = victim;
         cnt_in  = lfus_pkg::CNT_W'(1);
         gone_in = slot_key_ff[victim];
      end
   end

   // a newly placed key starts at age 0
   always_comb begin
      age_next = age_raised;
      if (!hit) begin
         age_next[slot_in] = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frames_ff     <= lfus_pkg::CFG_RESET;
         in_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         slot_valid_ff <= '0;
      end else begin
         if (csr_we) begin
            frames_ff <= csr_wdata;
         end
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (advance && !hit) begin
            slot_valid_ff[slot_in] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_key_ff <= req_tdata;
      end
      if (advance) begin
         slot_age_ff <= age_next;
         if (hit) begin
            slot_count_ff[slot_in] <= cnt_in;
         end else begin
            slot_key_ff[slot_in]   <= in_key_ff;
            slot_count_ff[slot_in] <= cnt_in;
         end
         hit_ff   <= hit;
         evict_ff <= !hit && !free_found;
         gone_ff  <= gone_in;
         slot_ff  <= slot_in;
         cnt_ff   <= cnt_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = {evict_ff, hit_ff};
   assign rsp_tdata  = {4'd0, cnt_ff, slot_ff, gone_ff};

endmodule

`default_nettype wire

[tb/sv/lfu_slot_checker.sv]
`timescale 1ns / 1ps

module lfu_slot_checker (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               req_tvalid,
   input  wire                               req_tready,
   input  wire  [15:0]                       req_tdata,   // candidate_id
   input  wire                               rsp_tvalid,
   input  wire                               rsp_tready,
   // evicted_id[15:0], slot_index[19:16], count_after[35:20], zero pad
   input  wire  [lfus_pkg::OUT_DATA_W-1:0]   rsp_tdata,
   // was_hit[0], did_evict[1]
   input  wire  [lfus_pkg::OUT_USER_W-1:0]   rsp_tuser,
   input  wire                               csr_we,
   input  wire  [lfus_pkg::CFG_W-1:0]        csr_wdata,
   output int                                mismatch_count,
   output int                                pending_count
);
   import lfus_pkg::*;

   typedef struct packed {
      logic         hit;
      logic         evict;
      key_type      evicted_id;
      slot_idx_type slot;
      count_type    count_after;
   } slot_outcome_type;

   logic [CFG_W-1:0] active_frames = CFG_RESET;
   logic             entry_valid [SLOTS];
   key_type          entry_key   [SLOTS];
   count_type        entry_count [SLOTS];
   age_type          entry_age   [SLOTS];
   slot_outcome_type outcome_q   [$];

   function automatic logic [15:0] bump(input logic [15:0] v);
      return (v == 16'hFFFF) ? v : v + 16'd1;
   endfunction

   function automatic slot_outcome_type access_slot_table(input key_type k);
      slot_outcome_type r;
      int               lim;
      int               best;
      int               i;
      lim = (active_frames == 0) ? 1 :
            (active_frames > SLOTS) ? SLOTS : int'(active_frames);
      r = '0;
      for (i = 0; i < lim; i++) begin
         if (!r.hit && entry_valid[i] && entry_key[i] == k) begin
            r.hit  = 1'b1;
            r.slot = slot_idx_type'(i);
         end
      end
      // aging happens before victim choice
      for (i = 0; i < lim; i++) begin
         if (entry_valid[i]) begin
            entry_age[i] = bump(entry_age[i]);
         end
      end
      if (r.hit) begin
         entry_count[r.slot] = bump(entry_count[r.slot]);
      end else begin
         best = -1;
         for (i = lim - 1; i >= 0; i--) begin
            if (!entry_valid[i]) begin
               best = i;
            end
         end
         if (best < 0) begin
            best = 0;
            for (i = 1; i < lim; i++) begin
               if (entry_count[i] < entry_count[best] ||
                   (entry_count[i] == entry_count[best] &&
                    entry_age[i] > entry_age[best])) begin
                  best = i;
               end
            end
            r.evict      = 1'b1;
            r.evicted_id = entry_key[best];
         end
         r.slot            = slot_idx_type'(best);
         entry_valid[best] = 1'b1;
         entry_key[best]   = k;
         entry_count[best] = 16'd1;
         entry_age[best]   = 16'd0;
      end
      r.count_after = entry_count[r.slot];
      return r;
   endfunction

   always @(posedge clock) begin
      slot_outcome_type got;
      slot_outcome_type want;
      int               i;
      if (reset) begin
         active_frames = CFG_RESET;
         for (i = 0; i < SLOTS; i++) begin
            entry_valid[i] = 1'b0;
         end
         outcome_q.delete();
      end else begin
         if (csr_we) begin
            active_frames = csr_wdata;
         end
         if (rsp_tvalid && rsp_tready) begin
            got.hit         = rsp_tuser[0];
            got.evict       = rsp_tuser[1];
            got.evicted_id  = rsp_tdata[15:0];
            got.slot        = rsp_tdata[19:16];
            got.count_after = rsp_tdata[35:20];
            if (outcome_q.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("%0t: unexpected item hit=%0b evict=%0b id=%h slot=%0d cnt=%0d",
                           $time, got.hit, got.evict, got.evicted_id, got.slot,
                           got.count_after);
               end
            end else begin
               want = outcome_q.pop_front();
               if (got.hit !== want.hit || got.evict !== want.evict ||
                   got.evicted_id !== want.evicted_id || got.slot !== want.slot ||
                   got.count_after !== want.count_after) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display("%0t: exp hit=%0b evict=%0b id=%h slot=%0d cnt=%0d",
                              $time, want.hit, want.evict, want.evicted_id, want.slot,
                              want.count_after);
                     $display("%0t: act hit=%0b evict=%0b id=%h slot=%0d cnt=%0d",
                              $time, got.hit, got.evict, got.evicted_id, got.slot,
                              got.count_after);
                  end
               end
            end
         end
         if (req_tvalid && req_tready) begin
            outcome_q = {outcome_q, access_slot_table(req_tdata)};
         end
      end
      pending_count = outcome_q.size();
   end

endmodule

[tb/sv/tb_lfu_slot_replacement_oldest_tie_unit.sv]
`timescale 1ns / 1ps

module tb_lfu_slot_replacement_oldest_tie_unit;
   import lfus_pkg::*;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [15:0]           req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [OUT_DATA_W-1:0] rsp_tdata;
   logic [OUT_USER_W-1:0] rsp_tuser;
   logic                  csr_we     = 1'b0;
   logic [CFG_W-1:0]      csr_wdata  = '0;

   int      mismatch_count;
   int      pending_count;
   bit      idle_on  = 1'b0;
   bit      hold_rsp = 1'b0;
   key_type key_pool [20];

   lfu_slot_replacement_oldest_tie_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   lfu_slot_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   initial begin
      forever begin
         #4 clock = ~clock;
      end
   end

   initial begin
      #8_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   task automatic send_key(input key_type key);
      int gap;
      if (idle_on && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 19);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= key;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_frames(input logic [CFG_W-1:0] value);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [CFG_W-1:0] pick_frames();
      case ($urandom_range(0, 9))
         0: return 5'd1;
         1: return 5'd16;
         2: return 5'd0;
         3: return 5'd31;
         4: return 5'd17;
         5: return 5'($urandom_range(0, 31));
         default: return 5'($urandom_range(2, 15));
      endcase
   endfunction

   // skewed pick from a pool slightly larger than the active table
   task automatic run_phase(input logic [CFG_W-1:0] frames, input int n_items);
      int lim;
      int psize;
      int k;
      lim   = (frames == 0) ? 1 : (frames > SLOTS) ? SLOTS : int'(frames);
      psize = lim + $urandom_range(1, 4);
      for (k = 0; k < 20; k++) begin
         if ($urandom_range(0, 2) == 0) begin
            key_pool[k] = key_type'($urandom);
         end
      end
      for (k = 0; k < n_items; k++) begin
         if ($urandom_range(0, 6) == 0) begin
            send_key(key_type'($urandom));
         end else begin
            send_key(key_pool[$urandom_range(0, $urandom_range(0, psize - 1))]);
         end
      end
   endtask

   // result side
   initial begin
      int stall;
      wait (!reset);
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp_tready <= 1'b0;
            stall = 0;
            while (stall < 300) begin
               @(posedge clock);
               stall++;
            end
            hold_rsp = 1'b0;
         end else if (idle_on && $urandom_range(0, 7) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin
      int               sent;
      int               phase;
      int               n;
      int               k;
      logic [CFG_W-1:0] f;
      for (k = 0; k < 20; k++) begin
         key_pool[k] = key_type'($urandom);
      end
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // ties on equal count, broken by age
      send_key(16'h0F0F);
      send_key(16'hF0F0);
      wait_drained();
      write_frames(5'd3);
      repeat (40) send_key(16'hC3C3);
      send_key(16'h3C3C);
      send_key(16'hC3C3);
      wait_drained();

      idle_on = 1'b1;
      write_frames(5'd1);
      send_key(16'h0000);
      send_key(16'hFFFF);
      send_key(16'hFFFF);
      send_key(16'h5555);
      wait_drained();
      write_frames(5'd0);
      send_key(16'h5555);
      send_key(16'hAAAA);
      wait_drained();
      write_frames(5'd16);
      send_key(16'hF0F0);
      send_key(16'h0000);
      send_key(16'hFFFF);
      send_key(16'h0000);
      send_key(16'h8001);
      wait_drained();
      write_frames(5'd2);
      send_key(16'h7FFE);
      send_key(16'h0001);
      wait_drained();
      write_frames(5'd31);
      send_key(16'h0000);
      send_key(16'hC3C3);
      send_key(16'h8001);
      wait_drained();
      write_frames(5'd17);
      send_key(16'hFFFF);
      send_key(16'h1234);

      sent  = 0;
      phase = 0;
      while (sent < 1300) begin
         wait_drained();
         f = pick_frames();
         write_frames(f);
         idle_on = (sent < 1100) && ($urandom_range(0, 3) != 0);
         n = $urandom_range(30, 120);
         if (phase == 3) begin
            idle_on  = 1'b0;
            hold_rsp = 1'b1;
            n        = 60;
         end
         run_phase(f, n);
         sent += n;
         phase++;
      end

      wait_drained();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
